### rtl/spdr_pkg.sv
package spdr_pkg;

    localparam int MAX_BINS_DEF   = 4096;
    localparam int MAX_PRESUM_DEF = 64;
    localparam int ACC_BITS_DEF   = 32;
    localparam int TRIG_BITS_DEF  = 16;

    localparam int CFG_IDX_W = 3;
    localparam int CORDIC_STEPS = 30;

    typedef enum logic [2:0] {
        REG_BINS_IN_USE    = 3'd0,
        REG_PRESUM_RATIO   = 3'd1,
        REG_IQ_RATIO_RECIP = 3'd2,
        REG_DC_OFFSET_I    = 3'd3,
        REG_DC_OFFSET_Q    = 3'd4,
        REG_PHASE_STEP     = 3'd5,
        REG_START_PHASE    = 3'd6
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_CORR,
        ST_MUL,
        ST_ROT,
        ST_ACC,
        ST_DEN,
        ST_DIV,
        ST_OUT
    } state_t;

    // divider request and status between sequencer and divider
    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

    // arctangent table, turns * 2^32
    function automatic logic [31:0] cordic_angle(input logic [4:0] k);
        logic [31:0] a;
        case (k)
            5'd0:  a = 32'd536870912;
            5'd1:  a = 32'd316933406;
            5'd2:  a = 32'd167458907;
            5'd3:  a = 32'd85004756;
            5'd4:  a = 32'd42667331;
            5'd5:  a = 32'd21354465;
            5'd6:  a = 32'd10679838;
            5'd7:  a = 32'd5340245;
            5'd8:  a = 32'd2670163;
            5'd9:  a = 32'd1335087;
            5'd10: a = 32'd667544;
            5'd11: a = 32'd333772;
            5'd12: a = 32'd166886;
            5'd13: a = 32'd83443;
            5'd14: a = 32'd41722;
            5'd15: a = 32'd20861;
            5'd16: a = 32'd10430;
            5'd17: a = 32'd5215;
            5'd18: a = 32'd2608;
            5'd19: a = 32'd1304;
            5'd20: a = 32'd652;
            5'd21: a = 32'd326;
            5'd22: a = 32'd163;
            5'd23: a = 32'd81;
            5'd24: a = 32'd41;
            5'd25: a = 32'd20;
            5'd26: a = 32'd10;
            5'd27: a = 32'd5;
            5'd28: a = 32'd3;
            5'd29: a = 32'd1;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage

### rtl/sar_presum_doppler_removal.sv
// sample items step through CORR, MUL, ROT and ACC, plus a phasor calculation at bin 0 of a pulse
// when phase_step is nonzero; on the final pulse of a line add two serial divisions
// (ST_DEN, ST_DIV, then ST_OUT) on one shared bit-serial divider, plus output stalls
// gain writes are taken in idle. one item at a time; ready is low while an item works
// aresetn is synchronous and active low: counters zero, registers to defaults,
// accumulator and gain memories hold no defined contents until written
module sar_presum_doppler_removal #(
    parameter int MAX_BINS   = spdr_pkg::MAX_BINS_DEF,
    parameter int MAX_PRESUM = spdr_pkg::MAX_PRESUM_DEF,
    parameter int ACC_BITS   = spdr_pkg::ACC_BITS_DEF,
    parameter int TRIG_BITS  = spdr_pkg::TRIG_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [spdr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                  cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_mode,
    input  logic [7:0]                   s_sample_i,
    input  logic [7:0]                   s_sample_q,
    input  logic [11:0]                  s_gain_address,
    input  logic [15:0]                  s_gain_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [31:0]           m_out_i,
    output logic signed [31:0]           m_out_q,
    output logic [11:0]                  m_out_bin,
    output logic                         m_last_bin,
    output logic                         m_saturated
);
    import spdr_pkg::*;

    localparam int AW  = $clog2(MAX_BINS);
    localparam int LW  = (MAX_PRESUM > 1) ? $clog2(MAX_PRESUM) : 1;
    localparam int TW  = TRIG_BITS + 2;
    localparam int NUM_W = ACC_BITS + 8;
    localparam int PW  = $clog2(MAX_PRESUM + 1);
    localparam int DEN_W = PW + 16;
    localparam int PRW = 26 + TW;
    localparam logic signed [ACC_BITS-1:0] ACC_HI = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] ACC_LO = {1'b1, {(ACC_BITS-1){1'b0}}};

    // configuration registers
    logic [12:0] bins_reg;
    logic [6:0]  presum_reg;
    logic [15:0] iqr_reg;
    logic signed [15:0] dci_reg, dcq_reg;
    logic [31:0] pstep_reg, phase_reg;

    state_t state_reg, state_next;
    logic [AW-1:0] bin_reg;
    logic [LW-1:0] line_reg;
    logic signed [TW-1:0] cos_reg, sin_reg;
    logic signed [25:0] di_reg, dq_reg;
    logic signed [PRW-1:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [ACC_BITS-1:0] si_reg, sq_reg;
    logic clip_reg, sat_reg, comp_reg, endp_reg, lastl_reg;
    logic [AW-1:0] obin_reg;
    logic [7:0] smp_i_reg, smp_q_reg;
    logic [DEN_W-1:0] den_reg;
    logic signed [31:0] oi_reg;

    // clamped lengths
    logic [AW:0] nb;
    logic [PW-1:0] np;
    always_comb begin
        if (bins_reg == 13'd0) nb = (AW+1)'(1);
        else if (32'(bins_reg) > MAX_BINS) nb = (AW+1)'(MAX_BINS);
        else nb = (AW+1)'(bins_reg);
        if (presum_reg == 7'd0) np = PW'(1);
        else if (32'(presum_reg) > MAX_PRESUM) np = PW'(MAX_PRESUM);
        else np = PW'(presum_reg);
    end

    // shared cordic and divider
    logic cordic_start, cordic_done;
    logic signed [TW-1:0] cordic_c, cordic_s;
    spdr_cordic #(.TRIG_BITS(TRIG_BITS)) u_cordic (
        .aclk(aclk), .aresetn(aresetn), .start(cordic_start), .phase(phase_reg),
        .done(cordic_done), .cos_out(cordic_c), .sin_out(cordic_s)
    );

    div_ctl_t div_ctl;
    div_sts_t div_sts;
    logic [NUM_W-1:0] div_num, div_quo;
    logic [ACC_BITS-1:0] mag;
    spdr_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
        .aclk(aclk), .aresetn(aresetn), .ctl(div_ctl), .num(div_num),
        .den(den_reg), .sts(div_sts), .quo(div_quo)
    );

    // memories: accumulator holds {clip, sum_q, sum_i}, gain holds Q8.8
    logic acc_we, gain_we;
    logic [2*ACC_BITS:0] acc_wdata, acc_rdata;
    logic [15:0] gain_rdata;
    logic [AW-1:0] s_bin;
    assign s_bin = s_gain_address[AW-1:0];
    spdr_ram #(.WIDTH(2*ACC_BITS+1), .DEPTH(MAX_BINS)) u_acc (
        .aclk(aclk), .we(acc_we), .waddr(bin_reg), .wdata(acc_wdata),
        .raddr(bin_reg), .rdata(acc_rdata)
    );
    spdr_ram #(.WIDTH(16), .DEPTH(MAX_BINS)) u_gain (
        .aclk(aclk), .we(gain_we), .waddr(s_bin), .wdata(s_gain_value),
        .raddr(bin_reg), .rdata(gain_rdata)
    );

    logic s_fire, gain_ok;
    assign s_ready = (state_reg == ST_IDLE) && !m_valid;
    assign cfg_ready = (state_reg == ST_IDLE) && !m_valid;
    assign s_fire = s_valid && s_ready;
    assign gain_ok = (32'(s_gain_address) < MAX_BINS);
    assign gain_we = s_fire && s_mode && gain_ok;

    // saturating accumulate
    logic signed [ACC_BITS+1:0] ri_w, rq_w, ni_w, nq_w;
    logic signed [ACC_BITS-1:0] ai, aq;
    logic ci, cq;
    logic signed [PRW:0] ti, tq;
    always_comb begin
        ti = ((p0_reg - p1_reg) + (PRW+1)'(1 <<< (TRIG_BITS-1))) >>> TRIG_BITS;
        tq = ((p2_reg + p3_reg) + (PRW+1)'(1 <<< (TRIG_BITS-1))) >>> TRIG_BITS;
        ri_w = (ACC_BITS+2)'(ti);
        rq_w = (ACC_BITS+2)'(tq);
        if (line_reg == '0) begin
            ni_w = ri_w;
            nq_w = rq_w;
        end else begin
            ni_w = ri_w + (ACC_BITS+2)'($signed(acc_rdata[ACC_BITS-1:0]));
            nq_w = rq_w + (ACC_BITS+2)'($signed(acc_rdata[2*ACC_BITS-1:ACC_BITS]));
        end
        ci = 1'b0; cq = 1'b0;
        if (ni_w > (ACC_BITS+2)'(ACC_HI)) begin ai = ACC_HI; ci = 1'b1; end
        else if (ni_w < (ACC_BITS+2)'(ACC_LO)) begin ai = ACC_LO; ci = 1'b1; end
        else ai = ni_w[ACC_BITS-1:0];
        if (nq_w > (ACC_BITS+2)'(ACC_HI)) begin aq = ACC_HI; cq = 1'b1; end
        else if (nq_w < (ACC_BITS+2)'(ACC_LO)) begin aq = ACC_LO; cq = 1'b1; end
        else aq = nq_w[ACC_BITS-1:0];
        acc_wdata = {((line_reg != '0) && acc_rdata[2*ACC_BITS]) || ci || cq, aq, ai};
        acc_we = (state_reg == ST_ACC);
    end

    // divider operand: |sum| << 8 plus half the denominator
    // first division takes the in-phase sum, the restart the quadrature sum
    logic signed [ACC_BITS-1:0] cur_sum, start_sum;
    assign cur_sum = comp_reg ? sq_reg : si_reg;
    assign start_sum = (state_reg == ST_DIV) ? sq_reg : si_reg;
    assign mag = start_sum[ACC_BITS-1] ? ACC_BITS'(-start_sum) : ACC_BITS'(start_sum);
    assign div_num = {mag, 8'd0} + NUM_W'(den_reg >> 1);

    // quotient to signed 32 bit with saturation
    logic signed [31:0] res;
    logic res_sat;
    always_comb begin
        res_sat = 1'b0;
        if (den_reg == '0) begin
            res_sat = 1'b1;
            if (cur_sum == '0) res = '0;
            else if (cur_sum[ACC_BITS-1]) res = 32'sh8000_0000;
            else res = 32'sh7fff_ffff;
        end else if (!cur_sum[ACC_BITS-1]) begin
            if (div_quo > NUM_W'(32'h7fff_ffff)) begin
                res_sat = 1'b1; res = 32'sh7fff_ffff;
            end else res = div_quo[31:0];
        end else begin
            if (div_quo > NUM_W'(33'h8000_0000)) begin
                res_sat = 1'b1; res = 32'sh8000_0000;
            end else res = -div_quo[31:0];
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        cordic_start = 1'b0;
        div_ctl.start = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && !s_mode) begin
                    if (bin_reg == '0 && pstep_reg != '0) begin
                        state_next = ST_CORDIC;
                        cordic_start = 1'b1;
                    end else begin
                        state_next = ST_CORR;
                    end
                end
            end
            ST_CORDIC: if (cordic_done) state_next = ST_CORR;
            ST_CORR:   state_next = ST_MUL;
            ST_MUL:    state_next = ST_ROT;
            ST_ROT:    state_next = ST_ACC;
            ST_ACC:    state_next = lastl_reg ? ST_DEN : ST_IDLE;
            ST_DEN: begin
                div_ctl.start = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_sts.done) begin
                    if (comp_reg) state_next = ST_OUT;
                    else begin
                        div_ctl.start = 1'b1;
                    end
                end
            end
            ST_OUT:    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    logic signed [25:0] di_w, dq_w;
    logic [23:0] sc;
    assign sc = smp_i_reg * iqr_reg;
    assign di_w = 26'(($signed({2'b0, sc}) + 26'sd32) >>> 6) - 26'(dci_reg);
    assign dq_w = $signed({2'b0, smp_q_reg, 8'd0}) - 26'(dcq_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            bins_reg   <= 13'd4096;
            presum_reg <= 7'd1;
            iqr_reg    <= 16'd16384;
            dci_reg    <= '0;
            dcq_reg    <= '0;
            pstep_reg  <= '0;
            phase_reg  <= '0;
            bin_reg    <= '0;
            line_reg   <= '0;
            cos_reg    <= TW'(1 <<< TRIG_BITS);
            sin_reg    <= '0;
            m_valid    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_BINS_IN_USE:    bins_reg <= cfg_data[12:0];
                    REG_PRESUM_RATIO:   presum_reg <= cfg_data[6:0];
                    REG_IQ_RATIO_RECIP: iqr_reg <= cfg_data[15:0];
                    REG_DC_OFFSET_I:    dci_reg <= cfg_data[15:0];
                    REG_DC_OFFSET_Q:    dcq_reg <= cfg_data[15:0];
                    REG_PHASE_STEP:     pstep_reg <= cfg_data;
                    REG_START_PHASE:    phase_reg <= cfg_data;
                    default: ;
                endcase
            end
            // phasor for this pulse
            if (s_fire && !s_mode && bin_reg == '0) begin
                phase_reg <= phase_reg + pstep_reg;
                if (pstep_reg == '0) begin
                    cos_reg <= TW'(1 <<< TRIG_BITS);
                    sin_reg <= '0;
                end
            end
            if (state_reg == ST_CORDIC && cordic_done) begin
                cos_reg <= cordic_c;
                sin_reg <= cordic_s;
            end
            // counters advance as the sum is written
            if (state_reg == ST_ACC) begin
                if (32'(bin_reg) + 1 >= 32'(nb)) begin
                    bin_reg <= '0;
                    line_reg <= lastl_reg ? '0 : line_reg + 1'b1;
                end else begin
                    bin_reg <= bin_reg + 1'b1;
                end
            end
            if (m_valid && m_ready) m_valid <= 1'b0;
            else if (state_reg == ST_OUT) m_valid <= 1'b1;
        end
        // datapath registers
        if (s_fire) begin
            smp_i_reg <= s_sample_i;
            smp_q_reg <= s_sample_q;
        end
        if (state_reg == ST_CORR) begin
            di_reg <= di_w;
            dq_reg <= dq_w;
            lastl_reg <= (32'(line_reg) + 1 >= 32'(np));
            endp_reg  <= (32'(bin_reg) + 1 >= 32'(nb));
            obin_reg  <= bin_reg;
        end
        if (state_reg == ST_MUL) begin
            p0_reg <= PRW'(di_reg * cos_reg);
            p1_reg <= PRW'(dq_reg * sin_reg);
            p2_reg <= PRW'(dq_reg * cos_reg);
            p3_reg <= PRW'(di_reg * sin_reg);
        end
        // gain read data is still for this bin here
        if (state_reg == ST_ACC) begin
            si_reg <= ai;
            sq_reg <= aq;
            clip_reg <= acc_wdata[2*ACC_BITS];
            comp_reg <= 1'b0;
            den_reg <= DEN_W'(np * gain_rdata);
        end
        if (state_reg == ST_DEN) begin
            sat_reg <= clip_reg;
        end
        if (state_reg == ST_DIV && div_sts.done) begin
            if (!comp_reg) begin
                oi_reg <= res;
                comp_reg <= 1'b1;
            end else begin
                m_out_i <= oi_reg;
                m_out_q <= res;
            end
            sat_reg <= sat_reg | res_sat;
        end
        if (state_reg == ST_OUT) begin
            m_out_bin <= 12'(obin_reg);
            m_last_bin <= endp_reg;
            m_saturated <= sat_reg;
        end
    end

    // no transfer while a result still waits
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input accepted while result pending");
    a_out_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_OUT))
        else $error("result without division");
    a_cordic_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cordic_start |=> state_reg == ST_CORDIC)
        else $error("phasor started outside sequence");

endmodule

### rtl/spdr_ram.sv
module spdr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/spdr_cordic.sv
module spdr_cordic #(
    parameter int TRIG_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [31:0]                 phase,
    output logic                        done,
    output logic signed [TRIG_BITS+1:0] cos_out,
    output logic signed [TRIG_BITS+1:0] sin_out
);
    import spdr_pkg::*;

    localparam int SH = 30 - TRIG_BITS;

    logic signed [33:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [4:0] k_reg, k_next;
    logic       busy_reg, busy_next, flip_reg, flip_next, done_next;
    logic       done_reg;
    logic signed [TRIG_BITS+1:0] c_reg, c_next, s_reg, s_next;
    logic [31:0] p;
    logic        fl;
    logic signed [33:0] xr, yr;

    // one rotation per cycle, 30 steps
    always_comb begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        k_next = k_reg;
        busy_next = busy_reg;
        flip_next = flip_reg;
        c_next = c_reg;
        s_next = s_reg;
        done_next = 1'b0;
        fl = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
        p = fl ? phase + 32'h8000_0000 : phase;
        xr = (x_reg + (34'sd1 <<< (SH - 1))) >>> SH;
        yr = (y_reg + (34'sd1 <<< (SH - 1))) >>> SH;
        if (start) begin
            x_next = 34'sd652032874;
            y_next = '0;
            z_next = {{2{p[31]}}, p};
            k_next = '0;
            flip_next = fl;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (k_reg == 5'(CORDIC_STEPS)) begin
                c_next = flip_reg ? -xr[TRIG_BITS+1:0] : xr[TRIG_BITS+1:0];
                s_next = flip_reg ? -yr[TRIG_BITS+1:0] : yr[TRIG_BITS+1:0];
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                if (!z_reg[33]) begin
                    x_next = x_reg - (y_reg >>> k_reg);
                    y_next = y_reg + (x_reg >>> k_reg);
                    z_next = z_reg - $signed({2'b00, cordic_angle(k_reg)});
                end else begin
                    x_next = x_reg + (y_reg >>> k_reg);
                    y_next = y_reg - (x_reg >>> k_reg);
                    z_next = z_reg + $signed({2'b00, cordic_angle(k_reg)});
                end
                k_next = k_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        k_reg <= k_next;
        flip_reg <= flip_next;
        c_reg <= c_next;
        s_reg <= s_next;
    end

    assign done = done_reg;
    assign cos_out = c_reg;
    assign sin_out = s_reg;

endmodule

### rtl/spdr_div.sv
module spdr_div #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  spdr_pkg::div_ctl_t    ctl,
    input  logic [NUM_W-1:0]      num,
    input  logic [DEN_W-1:0]      den,
    output spdr_pkg::div_sts_t    sts,
    output logic [NUM_W-1:0]      quo
);
    import spdr_pkg::*;

    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W:0]   r_reg, r_next;
    logic [DEN_W-1:0] d_reg, d_next;
    logic [CW-1:0]    n_reg, n_next;
    logic             busy_reg, busy_next, done_reg, done_next;
    logic [DEN_W:0]   sh;

    // restoring division, one quotient bit per cycle
    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        n_next = n_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        sh = {r_reg[DEN_W-1:0], q_reg[NUM_W-1]};
        if (ctl.start) begin
            q_next = num;
            r_next = '0;
            d_next = den;
            n_next = CW'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (sh >= {1'b0, d_reg}) begin
                r_next = sh - {1'b0, d_reg};
                q_next = {q_reg[NUM_W-2:0], 1'b1};
            end else begin
                r_next = sh;
                q_next = {q_reg[NUM_W-2:0], 1'b0};
            end
            n_next = n_reg - 1'b1;
            if (n_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        n_reg <= n_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quo = q_reg;

endmodule
